// ===== rtl/core/isf_pkg.sv =====
// isf_pkg: shared constants for the inertial scroll flywheel
// no dependencies
package isf_pkg;
   localparam logic [1:0] CMD_MOVE    = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;
   localparam logic       CSR_FRICTION = 1'b0;
   localparam logic       CSR_WINDOW   = 1'b1;
   localparam logic [15:0] FRICTION_RESET = 16'd512;
   localparam logic [9:0]  WINDOW_RESET   = 10'd70;
   localparam logic [19:0] ONE_SECOND_US  = 20'd1000000;
   // one million is 64 * 15625; digit divider by 15625 uses a reciprocal
   localparam logic [13:0] CDIV_D     = 14'd15625;
   localparam logic [30:0] CDIV_RECIP = 31'd1125899907;   // ceil(2^44 / 15625)
endpackage

// ===== rtl/core/inertia_scroll_flywheel.sv =====
// inertia_scroll_flywheel: one scroll axis with momentum, q16.16
// depends on isf_pkg
//
// channel  dir  fields (tdata low bit up)
// req_     in   tdata: cmd[1:0] delta[33:2] time_ms[65:34] elapsed_us[85:66]
// rsp_     out  tdata: displacement[31:0] momentum_out[63:32] position[95:64]
//               released[96]
// csr_     in   write enable, index, 16-bit data
//
// move and no-op items go straight to the response; a release walks the stored
// samples, then runs a shift-subtract divider for the span (one bit a cycle); a
// tick uses a 16-bit digit divider by 15625 for its two divisions by one million
// synchronous active-high reset; ring contents are not cleared
// req_tready is low while an item is in work or a result waits to be taken
module inertia_scroll_flywheel
   import isf_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // cmd, delta, time_ms, elapsed_us, zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // displacement, momentum_out, position, released
   input  logic         csr_wen,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);
   localparam int IW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int CW = $clog2(SAMPLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(SAMPLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_WALK, S_RDWAIT, S_RDCHK, S_DIVSET, S_DIV, S_DIVEND,
      S_FMUL, S_TMUL, S_CQ, S_CR, S_TDIVEND, S_RESP
   } state_type;

   state_type state_ff;
   logic [15:0] friction_ff;
   logic [9:0]  window_ff;
   logic [31:0] pos_ff, mom_ff, disp_ff;
   logic        rel_ff;
   logic [CW-1:0] count_ff, walk_ff;
   logic [IW-1:0] head_ff, slot_ff;
   logic [31:0] now_ff, start_ff;
   logic [19:0] elapsed_ff;
   logic [47:0] sum_ff;          // magnitude up to SAMPLE_DEPTH * 2^31
   logic        tick_ff;         // second tick pass: displacement
   // span divider: unsigned magnitude / divisor, restoring, one bit a cycle
   logic [63:0] dnum_ff;
   logic [31:0] dden_ff;
   logic [32:0] drem_ff;
   logic [6:0]  dcnt_ff;
   logic        dneg_ff;
   // divider by 15625: 16-bit digits, reciprocal estimate then remainder
   logic [47:0] cz_ff;           // dividend digits shift out, quotient digits in
   logic [13:0] crem_ff;
   logic [15:0] cq_ff;
   logic [1:0]  cdig_ff;

   logic [31:0] mem_delta [SAMPLE_DEPTH];
   logic [31:0] mem_time  [SAMPLE_DEPTH];
   logic [31:0] rd_delta_ff, rd_time_ff;

   wire [1:0]  in_cmd   = req_tdata[1:0];
   wire [31:0] in_delta = req_tdata[33:2];
   wire [31:0] in_time  = req_tdata[65:34];
   wire [19:0] in_el    = req_tdata[85:66];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {7'd0, rel_ff, pos_ff, mom_ff, disp_ff};

   always_ff @(posedge clock) begin
      rd_delta_ff <= mem_delta[slot_ff];
      rd_time_ff  <= mem_time[slot_ff];
      if (state_ff == S_IDLE && req_tvalid && in_cmd == CMD_MOVE) begin
         mem_delta[head_ff] <= in_delta;
         mem_time[head_ff]  <= in_time;
      end
   end

   logic [32:0] trial;
   logic [31:0] age;
   logic [63:0] sum_mag;
   logic [19:0] e_sat;
   logic [31:0] mag;
   logic [63:0] q_mag;
   logic [29:0] cv;
   logic [60:0] cprod;
   logic [29:0] cdiff;
   always_comb begin
      trial   = {drem_ff[31:0], dnum_ff[63]} - {1'b0, dden_ff};
      age     = now_ff - rd_time_ff;
      sum_mag = sum_ff[47] ? 64'(-$signed(sum_ff)) : 64'(sum_ff);
      e_sat   = (in_el > ONE_SECOND_US) ? ONE_SECOND_US : in_el;
      mag     = mom_ff[31] ? -mom_ff : mom_ff;
      q_mag   = dneg_ff ? -dnum_ff : dnum_ff;
      // partial dividend stays below 15625 * 2^16, so the estimate is exact
      cv      = {crem_ff, cz_ff[47:32]};
      cprod   = 61'(cv) * 61'(CDIV_RECIP);
      cdiff   = cv - 30'(cq_ff) * 30'(CDIV_D);
   end

   logic [43:0] fmul;
   logic [51:0] tmul;
   always_comb begin
      fmul = 44'(friction_ff) * 44'(elapsed_ff) * 44'd4;
      tmul = 52'(mag) * 52'(elapsed_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         friction_ff <= FRICTION_RESET;
         window_ff <= WINDOW_RESET;
         pos_ff <= '0; mom_ff <= '0; rel_ff <= 1'b1;
         count_ff <= '0; head_ff <= '0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_FRICTION) friction_ff <= csr_wdata;
            else window_ff <= csr_wdata[9:0];
         end
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               disp_ff <= '0;
               now_ff <= in_time;
               elapsed_ff <= e_sat;
               priority if (in_cmd == CMD_MOVE) begin
                  pos_ff <= pos_ff + in_delta;
                  head_ff <= (32'(head_ff) == SAMPLE_DEPTH - 1) ? '0 : head_ff + 1'b1;
                  if (count_ff != DEPTH_C) count_ff <= count_ff + 1'b1;
                  rel_ff <= 1'b0;
                  state_ff <= S_RESP;
               end else if (in_cmd == CMD_RELEASE && !rel_ff) begin
                  rel_ff <= 1'b1;
                  sum_ff <= '0; walk_ff <= '0; start_ff <= in_time;
                  slot_ff <= head_ff;
                  state_ff <= S_WALK;
               end else if (in_cmd == CMD_TICK && rel_ff) begin
                  state_ff <= S_FMUL;
               end else state_ff <= S_RESP;
            end
            S_WALK: begin
               if (walk_ff == count_ff) state_ff <= S_DIVSET;
               else begin
                  slot_ff <= (slot_ff == '0) ? IW'(SAMPLE_DEPTH - 1) : slot_ff - 1'b1;
                  state_ff <= S_RDWAIT;
               end
            end
            S_RDWAIT: state_ff <= S_RDCHK;
            S_RDCHK: begin
               if (age > 32'(window_ff)) state_ff <= S_DIVSET;
               else begin
                  sum_ff <= sum_ff + 48'($signed(rd_delta_ff));
                  start_ff <= rd_time_ff;
                  walk_ff <= walk_ff + 1'b1;
                  state_ff <= S_WALK;
               end
            end
            S_DIVSET: begin
               count_ff <= '0; head_ff <= '0;
               if (now_ff == start_ff) begin
                  mom_ff <= '0; state_ff <= S_RESP;
               end else begin
                  dnum_ff <= sum_mag * 64'd1000;
                  dden_ff <= now_ff - start_ff;
                  dneg_ff <= sum_ff[47];
                  drem_ff <= '0; dcnt_ff <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!trial[32]) begin
                  drem_ff <= trial; dnum_ff <= {dnum_ff[62:0], 1'b1};
               end else begin
                  drem_ff <= {drem_ff[31:0], dnum_ff[63]};
                  dnum_ff <= {dnum_ff[62:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == 7'd63) state_ff <= S_DIVEND;
            end
            S_DIVEND: begin
               priority if (!dneg_ff && dnum_ff > 64'h7FFF_FFFF) mom_ff <= 32'h7FFF_FFFF;
               else if (dneg_ff && dnum_ff > 64'h8000_0000) mom_ff <= 32'h8000_0000;
               else mom_ff <= q_mag[31:0];
               state_ff <= S_RESP;
            end
            S_FMUL: begin
               // friction step: friction * e * 256 / 1e6 = friction * e * 4 / 15625
               cz_ff <= {4'd0, fmul};
               crem_ff <= '0; cdig_ff <= '0; tick_ff <= 1'b0;
               state_ff <= S_CQ;
            end
            S_CQ: begin
               cq_ff <= cprod[59:44];
               state_ff <= S_CR;
            end
            S_CR: begin
               crem_ff <= cdiff[13:0];
               cz_ff <= {cz_ff[31:0], cq_ff};
               cdig_ff <= cdig_ff + 1'b1;
               state_ff <= (cdig_ff == 2'd2) ? S_TDIVEND : S_CQ;
            end
            S_TDIVEND: begin
               if (!tick_ff) begin
                  // first pass done: apply friction
                  if (33'(mag) <= cz_ff[32:0]) mom_ff <= '0;
                  else if (!mom_ff[31]) mom_ff <= mom_ff - cz_ff[31:0];
                  else mom_ff <= mom_ff + cz_ff[31:0];
                  state_ff <= S_TMUL;
               end else begin
                  disp_ff <= dneg_ff ? -cz_ff[31:0] : cz_ff[31:0];
                  state_ff <= S_RESP;
               end
            end
            S_TMUL: begin
               // displacement magnitude: (mag * e / 64) / 15625, truncated
               cz_ff <= {2'd0, tmul[51:6]};
               dneg_ff <= mom_ff[31];
               crem_ff <= '0; cdig_ff <= '0; tick_ff <= 1'b1;
               state_ff <= S_CQ;
            end
            S_RESP: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for inertia_scroll_flywheel
// depends on isf_pkg and the rtl top; predicts each result and compares in order
`timescale 1ns / 100ps

module tb_top;
   import isf_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;   // cmd, delta, time_ms, elapsed_us, zero fill
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;        // displacement, momentum_out, position, released
   logic         csr_wen = 1'b0;
   logic         csr_index = 1'b0;
   logic [15:0]  csr_wdata = '0;

   inertia_scroll_flywheel dut (.*);

   always #1 clock = ~clock;

   typedef struct packed {
      logic        released;
      logic [31:0] position;
      logic [31:0] momentum;
      logic [31:0] displacement;
   } axis_result_type;

   // predictor state, mirrors the block
   logic [15:0] fw_friction;
   logic [9:0]  fw_window;
   logic [31:0] fw_pos;
   logic signed [31:0] fw_mom;
   logic        fw_released;
   logic [31:0] smp_delta [16];
   logic [31:0] smp_time [16];
   int          smp_count;
   int          smp_head;

   axis_result_type pending_results[$];
   int  errors = 0;
   bit  idle_on = 1'b1;
   int  item_count = 0;
   int  stall_left = 0;
   logic [31:0] clock_ms = 0;

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // release: walk newest samples inside the window, momentum = sum*1000/span
   function automatic void coast_from_samples(logic [31:0] now);
      longint sum;
      logic [31:0] start;
      int used;
      int slot;
      sum = 0; start = 0; used = 0; slot = smp_head;
      fw_released = 1'b1;
      for (int k = 0; k < smp_count; k++) begin
         slot = (slot + 15) % 16;
         if (32'(now - smp_time[slot]) > {22'd0, fw_window}) break;
         used++;
         sum += longint'($signed(smp_delta[slot]));
         start = smp_time[slot];
      end
      fw_mom = 0;
      if (used > 0 && (now - start) != 0)
         fw_mom = sat32((sum * 1000) / longint'({32'd0, 32'(now - start)}));
      smp_count = 0;
      smp_head = 0;
   endfunction

   function automatic axis_result_type predict_axis(logic [1:0] cmd, logic [31:0] delta,
                                                    logic [31:0] tms, logic [19:0] eus);
      axis_result_type r;
      longint f, m, e;
      r.displacement = 0;
      case (cmd)
         CMD_MOVE: begin
            fw_pos = fw_pos + delta;
            smp_delta[smp_head] = delta;
            smp_time[smp_head] = tms;
            smp_head = (smp_head + 1) % 16;
            if (smp_count < 16) smp_count++;
            fw_released = 1'b0;
         end
         CMD_RELEASE: begin
            if (!fw_released) coast_from_samples(tms);
         end
         CMD_TICK: begin
            if (fw_released) begin
               e = (eus > ONE_SECOND_US) ? 1000000 : longint'(eus);
               f = (longint'(fw_friction) * e * 256) / 1000000;
               m = longint'(fw_mom);
               if ((m < 0 ? -m : m) <= f) m = 0;
               else if (m > 0) m -= f;
               else m += f;
               fw_mom = m[31:0];
               r.displacement = 32'((m * e) / 1000000);
            end
         end
         default: ;
      endcase
      r.momentum = fw_mom;
      r.position = fw_pos;
      r.released = fw_released;
      return r;
   endfunction

   task automatic random_idle();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_item(logic [1:0] cmd, logic [31:0] delta, logic [31:0] tms,
                            logic [19:0] eus);
      random_idle();
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, eus, tms, delta, cmd};
      pending_results.push_back(predict_axis(cmd, delta, tms, eus));
      item_count++;
      do @(posedge clock); while (!req_tready);
   endtask

   // write only when idle; block may still be finishing internal work
   task automatic write_reg(logic idx, logic [15:0] val);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_FRICTION) fw_friction = val;
      else fw_window = val[9:0];
   endtask

   // receiver with random stall bursts, checks each item against oldest prediction
   always @(posedge clock) begin
      axis_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[96:0];
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected item %h", $realtime, got);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (got.displacement !== want.displacement) begin
                  $display("%0t: displacement exp %h got %h", $realtime,
                           want.displacement, got.displacement);
                  errors++;
               end
               if (got.momentum !== want.momentum) begin
                  $display("%0t: momentum exp %h got %h", $realtime,
                           want.momentum, got.momentum);
                  errors++;
               end
               if (got.position !== want.position) begin
                  $display("%0t: position exp %h got %h", $realtime,
                           want.position, got.position);
                  errors++;
               end
               if (got.released !== want.released) begin
                  $display("%0t: released exp %b got %b", $realtime,
                           want.released, got.released);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 6);
         end else rsp_tready <= 1'b1;
      end
   end

   // a well-formed gesture: moves up to max_step ms apart, release, then ticks
   task automatic gesture(int moves, int max_step, int ticks);
      for (int i = 0; i < moves; i++) begin
         clock_ms += $urandom_range(0, max_step);
         send_item(CMD_MOVE, $urandom_range(0, 3) == 0 ? $urandom : 32'($signed(
                   $urandom_range(0, 2000000)) - 1000000), clock_ms, 20'($urandom));
      end
      clock_ms += $urandom_range(0, max_step);
      send_item(CMD_RELEASE, $urandom, clock_ms, 20'($urandom));
      for (int i = 0; i < ticks; i++)
         send_item(CMD_TICK, $urandom, $urandom,
                   20'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 40000)));
   endtask

   task automatic test_directed();
      send_item(CMD_TICK, 0, 0, 20'hfffff);            // tick coasting with zero momentum
      send_item(CMD_RELEASE, 0, 0, 20'd0);             // release while coasting
      send_item(2'd3, 32'hffffffff, 32'hffffffff, 20'hfffff);   // unused code
      send_item(CMD_MOVE, 32'h7fffffff, 32'hfffffff0, 20'd0);
      send_item(CMD_TICK, 0, 0, 20'd1000);             // tick while held
      send_item(CMD_MOVE, 32'h7fffffff, 32'h00000005, 20'd0);   // time wraps, pos wraps
      send_item(CMD_RELEASE, 0, 32'h00000010, 20'd0);  // saturating momentum
      send_item(CMD_TICK, 0, 0, 20'd1000000);
      send_item(CMD_TICK, 0, 0, 20'hfffff);            // elapsed beyond one second
      send_item(CMD_MOVE, 32'h80000000, 100, 20'd0);
      send_item(CMD_RELEASE, 0, 100, 20'd0);           // zero span
      send_item(CMD_MOVE, 32'h80000000, 200, 20'd0);
      send_item(CMD_MOVE, 32'h80000000, 201, 20'd0);
      send_item(CMD_RELEASE, 0, 202, 20'd0);           // negative saturation
      send_item(CMD_TICK, 0, 0, 20'd5000);
      send_item(CMD_MOVE, 32'h10000, 300, 20'd0);
      send_item(CMD_RELEASE, 0, 1000, 20'd0);          // sample too old
      for (int i = 0; i < 20; i++)                     // full ring overwrite
         send_item(CMD_MOVE, 32'h8000 * i, 400 + i, 20'd0);
      send_item(CMD_RELEASE, 0, 420, 20'd0);
      clock_ms = 1000;
   endtask

   task automatic test_config_sweep();
      write_reg(CSR_FRICTION, 16'hffff);
      write_reg(CSR_WINDOW, 16'd1);
      repeat (20) gesture($urandom_range(1, 20), 2, $urandom_range(1, 4));
      write_reg(CSR_FRICTION, 16'd0);
      write_reg(CSR_WINDOW, 16'd1000);
      repeat (20) gesture($urandom_range(1, 20), 100, $urandom_range(1, 4));
      write_reg(CSR_FRICTION, FRICTION_RESET);
      write_reg(CSR_WINDOW, 16'hfc00 | 16'(WINDOW_RESET));   // upper bits ignored
   endtask

   task automatic test_random();
      logic [15:0] fr;
      for (int ph = 0; ph < 6; ph++) begin
         fr = 16'($urandom);
         write_reg(CSR_FRICTION, fr);
         write_reg(CSR_WINDOW, 16'($urandom_range(1, 1000)));
         if (ph == 5) idle_on = 1'b0;
         while (item_count < 300 * (ph + 1) + 50) begin
            if ($urandom_range(0, 9) == 0)
               send_item(2'($urandom), $urandom, $urandom, 20'($urandom));
            else
               gesture($urandom_range(0, 18), $urandom_range(1, 40), $urandom_range(0, 6));
         end
      end
   endtask

   initial begin
      fw_friction = FRICTION_RESET;
      fw_window = WINDOW_RESET;
      fw_pos = 0; fw_mom = 0; fw_released = 1'b1;
      smp_count = 0; smp_head = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_random();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // timeout: ~1850 items, each at its worst case
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/isf_pkg.sv
rtl/core/inertia_scroll_flywheel.sv
tb/tb_top.sv
